[hdl/ign3d_pkg.sv]
`default_nettype none

package ign3d_pkg;

  localparam int COORD_W    = 40;
  localparam int OFFSET_W   = 24;
  localparam int PERM_W     = 8;
  localparam int TABLE_SIZE = 256;
  localparam int TABLE_AW   = $clog2(TABLE_SIZE);
  localparam int NOISE_W    = 18;
  localparam int SCALE_W    = NOISE_W + 1;
  localparam int OUT_FRAC   = 16;
  localparam int NOISE_LIMIT = 65536;

  // Fade polynomial 6t^5 - 15t^4 + 10t^3 in Horner form.
  localparam int FADE_A = 6;
  localparam int FADE_B = 15;
  localparam int FADE_C = 10;

  // Gradient direction selection codes.
  localparam logic [3:0] GRAD_U_LIMIT = 4'd8;
  localparam logic [3:0] GRAD_V_LIMIT = 4'd4;
  localparam logic [3:0] GRAD_X_A     = 4'd12;
  localparam logic [3:0] GRAD_X_B     = 4'd14;

  localparam logic FUNC_EVAL       = 1'b0;
  localparam logic FUNC_PERM_WRITE = 1'b1;

  typedef logic [1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [OFFSET_W-1:0]       offset_t;
  typedef logic [PERM_W-1:0]         perm_t;
  typedef logic signed [NOISE_W-1:0] noise_t;

endpackage

`default_nettype wire

[hdl/improved_gradient_noise_3d.sv]
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    func_i, coord_[xyz]_i, perm_index_i, perm_value_i
// out       output     out_valid_o / out_ready_i  noise_value_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while the pipeline is not held; a noise word leaves its result in the output register.
// The rate is set by the twelve-stage pipeline with seven copies of the
// permutation table, each read at two addresses in its own stage.
// A write word updates each table copy as it passes that copy's stage, and gives no result.
// When the output register is full and not taken, the whole pipeline holds.
// Reset clears the valid bits and the offsets; the table is undefined until written.

module improved_gradient_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire                      func_i,
  input  ign3d_pkg::coord_t        coord_x_i,
  input  ign3d_pkg::coord_t        coord_y_i,
  input  ign3d_pkg::coord_t        coord_z_i,
  input  ign3d_pkg::perm_t         perm_index_i,
  input  ign3d_pkg::perm_t         perm_value_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output ign3d_pkg::noise_t        noise_value_o,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  ign3d_pkg::cfg_idx_t      cfg_index_i,
  input  ign3d_pkg::offset_t       cfg_data_i
);

  import ign3d_pkg::*;

  localparam int CW  = FRAC_BITS + PERM_W;
  localparam int RW  = FRAC_BITS + 5;
  localparam int GW  = FRAC_BITS + 3;
  localparam int DW  = FRAC_BITS + 4;
  localparam int FPW = FRAC_BITS + 1 + RW;
  localparam int LPW = FRAC_BITS + 2 + DW;

  localparam logic signed [FPW-1:0] FADE_HALF = FPW'(1) << (FRAC_BITS - 1);
  localparam logic signed [LPW-1:0] LERP_HALF = LPW'(1) << (FRAC_BITS - 1);
  localparam logic signed [RW-1:0]  ONE_R     = RW'(2**FRAC_BITS);
  localparam logic signed [RW-1:0]  FADE_C_R  = RW'(FADE_C * 2**FRAC_BITS);
  localparam logic signed [RW-1:0]  FADE_B_R  = RW'(FADE_B * 2**FRAC_BITS);
  localparam logic signed [GW-1:0]  ONE_G     = GW'(2**FRAC_BITS);

  function automatic logic signed [RW-1:0] fade_mul(input logic [FRAC_BITS-1:0] t,
                                                    input logic signed [RW-1:0] r);
    logic signed [FPW-1:0] p;
    p = $signed({1'b0, t}) * r;
    p = (p + FADE_HALF) >>> FRAC_BITS;
    return p[RW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] lerp_mul(input logic [FRAC_BITS:0] t,
                                                    input logic signed [DW-1:0] d);
    logic signed [LPW-1:0] p;
    p = $signed({1'b0, t}) * d;
    p = (p + LERP_HALF) >>> FRAC_BITS;
    return p[DW-1:0];
  endfunction

  function automatic logic [FRAC_BITS:0] fade_clamp(input logic signed [RW-1:0] r);
    logic [FRAC_BITS:0] c;
    if (r < 0) begin
      c = '0;
    end else if (r > ONE_R) begin
      c = ONE_R[FRAC_BITS:0];
    end else begin
      c = r[FRAC_BITS:0];
    end
    return c;
  endfunction

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                input logic signed [GW-1:0] gx,
                                                input logic signed [GW-1:0] gy,
                                                input logic signed [GW-1:0] gz);
    logic signed [GW-1:0] gu;
    logic signed [GW-1:0] gv;
    gu = (h < GRAD_U_LIMIT) ? gx : gy;
    if (h < GRAD_V_LIMIT) begin
      gv = gy;
    end else if (h == GRAD_X_A || h == GRAD_X_B) begin
      gv = gx;
    end else begin
      gv = gz;
    end
    if (h[0]) begin
      gu = -gu;
    end
    if (h[1]) begin
      gv = -gv;
    end
    return gu + gv;
  endfunction

  // Configuration.
  offset_t offset_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        offset_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OFFSET_X: offset_q[0] <= cfg_data_i;
        REG_OFFSET_Y: offset_q[1] <= cfg_data_i;
        REG_OFFSET_Z: offset_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: the whole pipe advances unless the output word is stuck.
  logic en;
  logic out_valid_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic w1_q, w2_q, w3_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
      v11_q <= 1'b0;
      w1_q <= 1'b0; w2_q <= 1'b0; w3_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i && (func_i == FUNC_EVAL);
      w1_q  <= in_valid_i && (func_i == FUNC_PERM_WRITE);
      v2_q  <= v1_q;  w2_q <= w1_q;
      v3_q  <= v2_q;  w3_q <= w2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
      out_valid_q <= v11_q;
    end
  end

  // Stage 0: offset add and lattice split.
  logic [CW-1:0]        sum_d [3];
  logic [PERM_W-1:0]    cell_d [3];
  logic [FRAC_BITS-1:0] frac_d [3];

  always_comb begin
    sum_d[0] = coord_x_i[CW-1:0] + CW'(offset_q[0]);
    sum_d[1] = coord_y_i[CW-1:0] + CW'(offset_q[1]);
    sum_d[2] = coord_z_i[CW-1:0] + CW'(offset_q[2]);
    for (int i = 0; i < 3; i++) begin
      cell_d[i] = sum_d[i][FRAC_BITS +: PERM_W];
      frac_d[i] = sum_d[i][FRAC_BITS-1:0];
    end
  end

  // Stage registers (payload, no reset).
  logic [PERM_W-1:0]    cell1_q [3];
  logic [FRAC_BITS-1:0] frac1_q [3], frac2_q [3], frac3_q [3], frac4_q [3];
  perm_t                pidx1_q, pidx2_q, pidx3_q;
  perm_t                pval1_q, pval2_q, pval3_q;
  perm_t                pa2_q, pb2_q, cy2_q, cz2_q, cz3_q;
  perm_t                ph3_q [4];
  perm_t                hash4_q [4][2];
  logic signed [RW-1:0] fade2_q [3], fade3_q [3], fade4_q [3];
  logic [FRAC_BITS:0]   fade5_q [3], fade6_q [3];
  logic [FRAC_BITS:0]   fv7_q, fw7_q, fv8_q, fw8_q, fw9_q, fw10_q;
  logic signed [GW-1:0] grad5_q [8];
  logic signed [GW-1:0] lo6_q [4], lx7_q [4], lo8_q [2], ly9_q [2], lo10_q, lz11_q;
  logic signed [DW-1:0] dif6_q [4], dif8_q [2], dif10_q;
  noise_t               noise_q;

  // Permutation table copies: one for the first lookup level, two for the second and four for the third.
  perm_t perm_l1_q [TABLE_SIZE];
  perm_t perm_l2_q [2][TABLE_SIZE];
  perm_t perm_l3_q [4][TABLE_SIZE];

  logic [TABLE_AW-1:0] a_d [2];
  logic [TABLE_AW-1:0] base_d [4];

  always_comb begin
    a_d[0] = pa2_q + cy2_q;
    a_d[1] = pb2_q + cy2_q;
    for (int k = 0; k < 4; k++) begin
      base_d[k] = ph3_q[k] + cz3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (w1_q) begin
        perm_l1_q[pidx1_q] <= pval1_q;
      end
      pa2_q <= perm_l1_q[cell1_q[0]];
      pb2_q <= perm_l1_q[cell1_q[0] + 8'd1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        if (w2_q) begin
          perm_l2_q[k][pidx2_q] <= pval2_q;
        end
        ph3_q[2*k]     <= perm_l2_q[k][a_d[k]];
        ph3_q[2*k + 1] <= perm_l2_q[k][a_d[k] + 8'd1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        if (w3_q) begin
          perm_l3_q[k][pidx3_q] <= pval3_q;
        end
        hash4_q[k][0] <= perm_l3_q[k][base_d[k]];
        hash4_q[k][1] <= perm_l3_q[k][base_d[k] + 8'd1];
      end
    end
  end

  // Fade first step and gradients.
  logic signed [RW-1:0] fade1_d [3];
  logic signed [GW-1:0] grad_d [8];
  logic signed [GW-1:0] pos_d [3][2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fade1_d[i] = fade_mul(frac1_q[i],
                            $signed(RW'(frac1_q[i])) * $signed(RW'(FADE_A)) - FADE_B_R)
                   + FADE_C_R;
      pos_d[i][0] = $signed(GW'(frac4_q[i]));
      pos_d[i][1] = $signed(GW'(frac4_q[i])) - ONE_G;
    end
    // Corner i uses bit 0 for x, bit 1 for y and bit 2 for z.
    for (int i = 0; i < 8; i++) begin
      grad_d[i] = grad(hash4_q[2'((i & 1) * 2 + ((i >> 1) & 1))][1'((i >> 2) & 1)][3:0],
                       pos_d[0][1'(i & 1)], pos_d[1][1'((i >> 1) & 1)],
                       pos_d[2][1'((i >> 2) & 1)]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cell1_q[i] <= cell_d[i];
        frac1_q[i] <= frac_d[i];
        frac2_q[i] <= frac1_q[i];
        frac3_q[i] <= frac2_q[i];
        frac4_q[i] <= frac3_q[i];
        fade2_q[i] <= fade1_d[i];
        fade3_q[i] <= fade_mul(frac2_q[i], fade2_q[i]);
        fade4_q[i] <= fade_mul(frac3_q[i], fade3_q[i]);
        fade5_q[i] <= fade_clamp(fade_mul(frac4_q[i], fade4_q[i]));
        fade6_q[i] <= fade5_q[i];
      end
      pidx1_q <= perm_index_i;
      pval1_q <= perm_value_i;
      pidx2_q <= pidx1_q;
      pval2_q <= pval1_q;
      pidx3_q <= pidx2_q;
      pval3_q <= pval2_q;
      cy2_q   <= cell1_q[1];
      cz2_q   <= cell1_q[2];
      cz3_q   <= cz2_q;

      for (int i = 0; i < 8; i++) begin
        grad5_q[i] <= grad_d[i];
      end

      // Blend along x.
      for (int j = 0; j < 4; j++) begin
        lo6_q[j]  <= grad5_q[2*j];
        dif6_q[j] <= DW'(grad5_q[2*j + 1]) - DW'(grad5_q[2*j]);
        lx7_q[j]  <= GW'(DW'(lo6_q[j]) + lerp_mul(fade6_q[0], dif6_q[j]));
      end
      fv7_q <= fade6_q[1];
      fw7_q <= fade6_q[2];

      // Blend along y.
      for (int j = 0; j < 2; j++) begin
        lo8_q[j]  <= lx7_q[2*j];
        dif8_q[j] <= DW'(lx7_q[2*j + 1]) - DW'(lx7_q[2*j]);
        ly9_q[j]  <= GW'(DW'(lo8_q[j]) + lerp_mul(fv8_q, dif8_q[j]));
      end
      fv8_q <= fv7_q;
      fw8_q <= fw7_q;
      fw9_q <= fw8_q;

      // Blend along z.
      lo10_q  <= ly9_q[0];
      dif10_q <= DW'(ly9_q[1]) - DW'(ly9_q[0]);
      fw10_q  <= fw9_q;
      lz11_q  <= GW'(DW'(lo10_q) + lerp_mul(fw10_q, dif10_q));
    end
  end

  // Rescale to 16 fraction bits and saturate.
  logic signed [SCALE_W-1:0] scaled_d;

  if (FRAC_BITS > OUT_FRAC) begin : g_scale_down
    localparam int SH = FRAC_BITS - OUT_FRAC;
    localparam logic signed [GW:0] SCALE_HALF = (GW + 1)'(1) << (SH - 1);
    logic signed [GW:0] rnd_d;
    always_comb begin
      rnd_d    = ((GW + 1)'(lz11_q) + SCALE_HALF) >>> SH;
      scaled_d = rnd_d[SCALE_W-1:0];
    end
  end else begin : g_scale_up
    always_comb begin
      scaled_d = SCALE_W'(lz11_q) <<< (OUT_FRAC - FRAC_BITS);
    end
  end

  noise_t noise_d;

  always_comb begin
    if (scaled_d > SCALE_W'(NOISE_LIMIT)) begin
      noise_d = NOISE_W'(NOISE_LIMIT);
    end else if (scaled_d < -SCALE_W'(NOISE_LIMIT)) begin
      noise_d = -NOISE_W'(NOISE_LIMIT);
    end else begin
      noise_d = scaled_d[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_q <= noise_d;
    end
  end

  assign noise_value_o = noise_q;

endmodule

`default_nettype wire

[tb/improved_gradient_noise_3d_tb.sv]
`timescale 1ns / 100ps

module improved_gradient_noise_3d_tb;
  import ign3d_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 12;
  localparam int CYCLE_LIMIT = 200000;

  // Predicts the noise value of every accepted evaluation word and keeps the
  // pending results in order.
  class noise_scoreboard;
    perm_t   perm_copy [TABLE_SIZE];
    offset_t offs [3];
    noise_t  pending_noise [$];
    int      errors = 0;

    function longint fx_mul(longint a, longint b);
      longint p;
      p = a * b;
      return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function longint fade(longint t);
      longint r;
      r = FADE_A * t - FADE_B * (longint'(1) <<< FRAC);
      r = fx_mul(t, r) + FADE_C * (longint'(1) <<< FRAC);
      r = fx_mul(t, r);
      r = fx_mul(t, r);
      r = fx_mul(t, r);
      if (r < 0) r = 0;
      if (r > (longint'(1) <<< FRAC)) r = longint'(1) <<< FRAC;
      return r;
    endfunction

    function longint blend(longint t, longint a, longint b);
      return a + fx_mul(t, b - a);
    endfunction

    function longint grad(int hv, longint x, longint y, longint z);
      logic [3:0] h;
      longint u, v;
      h = hv[3:0];
      u = (h < GRAD_U_LIMIT) ? x : y;
      v = (h < GRAD_V_LIMIT) ? y : ((h == GRAD_X_A || h == GRAD_X_B) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function int hashed(int i);
      return int'(perm_copy[i & (TABLE_SIZE - 1)]);
    endfunction

    function void split(coord_t c, offset_t off, output int lat, output longint fr);
      longint s;
      s = longint'(c) + longint'({1'b0, off});
      lat = int'((s >>> FRAC) & 255);
      fr = s & ((longint'(1) <<< FRAC) - 1);
    endfunction

    function void note_word(logic f, coord_t cx_in, coord_t cy_in, coord_t cz_in,
                            perm_t pi, perm_t pv);
      int cx, cy, cz, a, aa, ab, b, ba, bb;
      longint x, y, z, u, v, w, x1, y1, z1, r;
      if (f == FUNC_PERM_WRITE) begin
        perm_copy[pi] = pv;
        return;
      end
      split(cx_in, offs[REG_OFFSET_X], cx, x);
      split(cy_in, offs[REG_OFFSET_Y], cy, y);
      split(cz_in, offs[REG_OFFSET_Z], cz, z);
      u = fade(x);
      v = fade(y);
      w = fade(z);
      x1 = x - (longint'(1) <<< FRAC);
      y1 = y - (longint'(1) <<< FRAC);
      z1 = z - (longint'(1) <<< FRAC);
      a  = hashed(cx) + cy;
      aa = hashed(a) + cz;
      ab = hashed(a + 1) + cz;
      b  = hashed(cx + 1) + cy;
      ba = hashed(b) + cz;
      bb = hashed(b + 1) + cz;
      r = blend(w,
            blend(v,
              blend(u, grad(hashed(aa), x, y, z), grad(hashed(ba), x1, y, z)),
              blend(u, grad(hashed(ab), x, y1, z), grad(hashed(bb), x1, y1, z))),
            blend(v,
              blend(u, grad(hashed(aa + 1), x, y, z1), grad(hashed(ba + 1), x1, y, z1)),
              blend(u, grad(hashed(ab + 1), x, y1, z1), grad(hashed(bb + 1), x1, y1, z1))));
      if (r > NOISE_LIMIT) r = NOISE_LIMIT;
      if (r < -NOISE_LIMIT) r = -NOISE_LIMIT;
      pending_noise.push_back(noise_t'(r));
    endfunction

    function void check_noise(noise_t got);
      noise_t want;
      if (pending_noise.size() == 0) begin
        $error("noise_value: unexpected result %0d", got);
        errors++;
        return;
      end
      want = pending_noise.pop_front();
      if (got !== want) begin
        $error("noise_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic func_i = FUNC_EVAL;
  coord_t coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  perm_t perm_index_i = '0, perm_value_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  cfg_idx_t cfg_index_i = '0;
  offset_t cfg_data_i = '0;
  wire in_ready_o, out_valid_o, cfg_ready_o;
  noise_t noise_value_o;

  noise_scoreboard sb;
  int cycle_count = 0;
  bit no_gaps = 0;
  bit hold_off = 0;

  improved_gradient_noise_3d #(.FRAC_BITS(FRAC)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .coord_x_i, .coord_y_i,
    .coord_z_i, .perm_index_i, .perm_value_i, .out_valid_o, .out_ready_i,
    .noise_value_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("improved_gradient_noise_3d_tb: done, errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge after the word went in.
  task automatic send_word(logic f, coord_t x, coord_t y, coord_t z, perm_t pi, perm_t pv);
    int n;
    in_valid_i = 1'b1;
    func_i = f;
    coord_x_i = x;
    coord_y_i = y;
    coord_z_i = z;
    perm_index_i = pi;
    perm_value_i = pv;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(f, x, y, z, pi, pv);
    @(negedge clk_i);
    n = gap_len();
    if (n > 0) begin
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_noise(coord_t x, coord_t y, coord_t z);
    send_word(FUNC_EVAL, x, y, z, perm_t'($urandom), perm_t'($urandom));
  endtask

  task automatic send_perm(perm_t pi, perm_t pv);
    send_word(FUNC_PERM_WRITE, coord_t'({$urandom, $urandom}),
              coord_t'({$urandom, $urandom}), coord_t'({$urandom, $urandom}), pi, pv);
  endtask

  task automatic write_offset(cfg_reg_e r, offset_t d);
    cfg_valid_i = 1'b1;
    cfg_index_i = r;
    cfg_data_i = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.offs[r] = d;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_noise.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return coord_t'({$urandom, $urandom});
    if (r < 9) return coord_t'($signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC));
    return coord_t'({$urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_00FF, 16'($urandom)});
  endfunction

  // Receiver: random stalls, plus one long hold-off while words keep coming.
  initial begin : receiver
    int n;
    bit held;
    held = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off && !held) begin
        held = 1'b1;
        out_ready_i = 1'b0;
        repeat (300) @(negedge clk_i);
      end
      n = $urandom_range(0, 99);
      if (no_gaps || n < 70) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b0;
        repeat (n < 95 ? $urandom_range(0, 2) : $urandom_range(10, 40)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_noise(noise_value_o);
  end

  initial begin : stimulus
    offset_t settings [4][3];
    int k, ph;
    sb = new;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_offset(REG_OFFSET_X, '0);
    write_offset(REG_OFFSET_Y, '0);
    write_offset(REG_OFFSET_Z, '0);
    // Every slot is loaded before the first evaluation reads the table.
    for (k = 0; k < TABLE_SIZE; k++) send_perm(perm_t'(k), perm_t'($urandom));

    send_perm(8'hFF, 8'hFF);
    send_perm(8'h00, 8'h00);
    send_noise('0, '0, '0);
    send_noise(40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF);
    send_noise(40'sh80_0000_0000, 40'sh80_0000_0000, 40'sh80_0000_0000);
    send_noise(-40'sd1, -40'sd1, -40'sd1);
    send_noise(40'sh00_00FF_FFFF, 40'sh00_00FF_8000, 40'sh00_00FF_0000);
    send_noise(40'sh00_0000_8000, 40'sh00_0000_8000, 40'sh00_0000_8000);
    send_noise(40'sh00_0000_FFFF, 40'sh00_0001_0000, -40'sh00_0000_8000);
    send_noise(40'sh55_5555_5555, 40'shAA_AAAA_AAAA, 40'sh12_3456_789A);
    send_noise(40'shAA_AAAA_AAAA, 40'sh55_5555_5555, 40'shED_CBA9_8765);
    for (k = 0; k < 6; k++) send_noise(rand_coord(), rand_coord(), rand_coord());

    settings[0] = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF};
    settings[1] = '{24'h00_8000, 24'h01_0000, 24'h00_FFFF};
    settings[2] = '{offset_t'($urandom), offset_t'($urandom), offset_t'($urandom)};
    settings[3] = '{24'h00_0000, 24'h00_0000, 24'h00_0000};
    for (ph = 0; ph < 4; ph++) begin
      drain();
      write_offset(REG_OFFSET_X, settings[ph][0]);
      write_offset(REG_OFFSET_Y, settings[ph][1]);
      write_offset(REG_OFFSET_Z, settings[ph][2]);
      no_gaps = (ph == 1);
      // The long receiver hold-off falls into this phase, while words keep coming.
      hold_off = (ph == 2);
      for (k = 0; k < 135; k++) begin
        if ($urandom_range(0, 99) < 12) send_perm(perm_t'($urandom), perm_t'($urandom));
        else send_noise(rand_coord(), rand_coord(), rand_coord());
      end
    end
    no_gaps = 0;
    hold_off = 0;

    drain();
    if (sb.errors == 0 && sb.pending_noise.size() == 0) begin
      $display("improved_gradient_noise_3d_tb: done, clean");
    end else begin
      $display("improved_gradient_noise_3d_tb: done, errors");
    end
    $finish;
  end

endmodule
